/* rtl/vcsg_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the velocity command safety gate.
// No dependencies; imported by velocity_command_safety_gate_core.
package vcsg_pkg;

	localparam int TimeW   = 32;
	localparam int VelW    = 16;
	localparam int TmoW    = 20;
	localparam int LimW    = 15;
	localparam int CfgW    = 20;
	localparam int CfgIdxW = 2;

	typedef logic [1:0] action_t;
	typedef logic [2:0] reason_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam action_t ACT_COMMAND = 2'd0;
	localparam action_t ACT_BRAKE   = 2'd1;
	localparam action_t ACT_STEP    = 2'd2;

	localparam reason_t REASON_ACTIVE          = 3'd0;
	localparam reason_t REASON_BAD_CLOCK       = 3'd1;
	localparam reason_t REASON_BRAKE_TIMEOUT   = 3'd2;
	localparam reason_t REASON_BRAKE           = 3'd3;
	localparam reason_t REASON_DISABLED        = 3'd4;
	localparam reason_t REASON_NO_COMMAND      = 3'd5;
	localparam reason_t REASON_BAD_COMMAND     = 3'd6;
	localparam reason_t REASON_COMMAND_TIMEOUT = 3'd7;

	localparam cfg_idx_t REG_COMMAND_TIMEOUT = 2'd0;
	localparam cfg_idx_t REG_BRAKE_TIMEOUT   = 2'd1;
	localparam cfg_idx_t REG_MAX_LINEAR      = 2'd2;
	localparam cfg_idx_t REG_MAX_ANGULAR     = 2'd3;

	localparam logic [TmoW-1:0] RST_TIMEOUT = 20'd500;
	localparam logic [LimW-1:0] RST_LIMIT   = 15'd1000;

	// Symmetric clamp of a signed velocity to [-lim, +lim].
	function automatic logic signed [VelW-1:0] clamp_sym(
		input logic signed [VelW-1:0] v,
		input logic [LimW-1:0] lim
	);
		logic signed [VelW:0] v_x;
		logic signed [VelW:0] hi;
		logic signed [VelW:0] lo;
		logic signed [VelW:0] r;
		v_x = {v[VelW-1], v};
		hi  = $signed({2'b00, lim});
		lo  = -hi;
		if (v_x > hi) begin
			r = hi;
		end else if (v_x < lo) begin
			r = lo;
		end else begin
			r = v_x;
		end
		return r[VelW-1:0];
	endfunction

	// True when now runs behind then or has moved on by more than limit.
	function automatic logic expired(
		input logic [TimeW-1:0] now,
		input logic [TimeW-1:0] then_t,
		input logic [TmoW-1:0] limit
	);
		logic [TimeW-1:0] diff;
		diff = now - then_t;
		return (now < then_t) || (diff > {{(TimeW-TmoW){1'b0}}, limit});
	endfunction

endpackage

/* rtl/velocity_command_safety_gate_core.sv */
`timescale 1ns / 1ps
// Velocity command safety gate: input register, state update and step decision,
// result register. Depends on vcsg_pkg.
//
//   Channel  Signals                                   Direction
//   in       in_valid/in_ready + 8 item fields         sink
//   out      out_valid/out_ready + 4 result fields     source
//   cfg      cfg_wr_en, cfg_index, cfg_data            sink, no handshake
//
// One beat is taken every cycle unless a step beat is blocked; a step beat's
// result is registered as it leaves the input register, other beats give none.
// Throughput is limited only by the single result register when out_ready is
// low. Reset is asynchronous and restores all limits and gate state. A step
// beat waits in the input register while the result register is full and
// unread; command and brake beats pass through regardless.
module velocity_command_safety_gate_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  vcsg_pkg::action_t              action,
	input  logic [vcsg_pkg::TimeW-1:0]     time_stamp,
	input  logic                           time_valid,
	input  logic signed [vcsg_pkg::VelW-1:0] linear_request,
	input  logic signed [vcsg_pkg::VelW-1:0] angular_request,
	input  logic                           request_valid,
	input  logic                           brake_on,
	input  logic                           motion_allowed,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [vcsg_pkg::VelW-1:0] linear_drive,
	output logic signed [vcsg_pkg::VelW-1:0] angular_drive,
	output logic                           stop,
	output vcsg_pkg::reason_t              reason,
	input  logic                           cfg_wr_en,
	input  vcsg_pkg::cfg_idx_t             cfg_index,
	input  logic [vcsg_pkg::CfgW-1:0]      cfg_data
);
	import vcsg_pkg::*;

	logic [TmoW-1:0] cmd_tmo_q;
	logic [TmoW-1:0] brk_tmo_q;
	logic [LimW-1:0] max_lin_q;
	logic [LimW-1:0] max_ang_q;

	logic                    valid_s1;
	action_t                 action_s1;
	logic [TimeW-1:0]        time_s1;
	logic                    time_valid_s1;
	logic signed [VelW-1:0]  lin_s1;
	logic signed [VelW-1:0]  ang_s1;
	logic                    req_valid_s1;
	logic                    brake_on_s1;
	logic                    enabled_s1;

	logic                    brake_seen_q;
	logic                    brake_engaged_q;
	logic [TimeW-1:0]        brake_time_q;
	logic                    cmd_seen_q;
	logic                    cmd_ok_q;
	logic signed [VelW-1:0]  held_lin_q;
	logic signed [VelW-1:0]  held_ang_q;
	logic [TimeW-1:0]        cmd_time_q;

	logic                    out_valid_q;
	logic signed [VelW-1:0]  lin_drive_q;
	logic signed [VelW-1:0]  ang_drive_q;
	logic                    stop_q;
	reason_t                 reason_q;

	logic    s1_adv;
	logic    out_free;
	reason_t step_reason;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_tmo_q <= RST_TIMEOUT;
			brk_tmo_q <= RST_TIMEOUT;
			max_lin_q <= RST_LIMIT;
			max_ang_q <= RST_LIMIT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_COMMAND_TIMEOUT: cmd_tmo_q <= cfg_data[TmoW-1:0];
				REG_BRAKE_TIMEOUT:   brk_tmo_q <= cfg_data[TmoW-1:0];
				REG_MAX_LINEAR:      max_lin_q <= cfg_data[LimW-1:0];
				REG_MAX_ANGULAR:     max_ang_q <= cfg_data[LimW-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign s1_adv   = valid_s1 && ((action_s1 != ACT_STEP) || out_free);
	assign in_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1     <= action;
			time_s1       <= time_stamp;
			time_valid_s1 <= time_valid;
			lin_s1        <= linear_request;
			ang_s1        <= angular_request;
			req_valid_s1  <= request_valid;
			brake_on_s1   <= brake_on;
			enabled_s1    <= motion_allowed;
		end
	end

	always_comb begin
		if (!time_valid_s1) begin
			step_reason = REASON_BAD_CLOCK;
		end else if (!brake_seen_q || expired(time_s1, brake_time_q, brk_tmo_q)) begin
			step_reason = REASON_BRAKE_TIMEOUT;
		end else if (brake_engaged_q) begin
			step_reason = REASON_BRAKE;
		end else if (!enabled_s1) begin
			step_reason = REASON_DISABLED;
		end else if (!cmd_seen_q) begin
			step_reason = REASON_NO_COMMAND;
		end else if (!cmd_ok_q) begin
			step_reason = REASON_BAD_COMMAND;
		end else if (expired(time_s1, cmd_time_q, cmd_tmo_q)) begin
			step_reason = REASON_COMMAND_TIMEOUT;
		end else begin
			step_reason = REASON_ACTIVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brake_seen_q    <= 1'b0;
			brake_engaged_q <= 1'b1;
			brake_time_q    <= '0;
			cmd_seen_q      <= 1'b0;
			cmd_ok_q        <= 1'b0;
			held_lin_q      <= '0;
			held_ang_q      <= '0;
			cmd_time_q      <= '0;
		end else if (s1_adv) begin
			if (action_s1 == ACT_COMMAND) begin
				cmd_seen_q <= 1'b1;
				cmd_time_q <= time_s1;
				cmd_ok_q   <= req_valid_s1 && time_valid_s1;
				if (req_valid_s1 && time_valid_s1) begin
					held_lin_q <= clamp_sym(lin_s1, max_lin_q);
					held_ang_q <= clamp_sym(ang_s1, max_ang_q);
				end else begin
					held_lin_q <= '0;
					held_ang_q <= '0;
				end
			end else if (action_s1 == ACT_BRAKE) begin
				if (!time_valid_s1) begin
					brake_seen_q    <= 1'b0;
					brake_engaged_q <= 1'b1;
				end else begin
					brake_seen_q    <= 1'b1;
					brake_engaged_q <= brake_on_s1;
					brake_time_q    <= time_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_adv && (action_s1 == ACT_STEP);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && (action_s1 == ACT_STEP)) begin
			reason_q <= step_reason;
			if (step_reason == REASON_ACTIVE) begin
				lin_drive_q <= held_lin_q;
				ang_drive_q <= held_ang_q;
				stop_q      <= 1'b0;
			end else begin
				lin_drive_q <= '0;
				ang_drive_q <= '0;
				stop_q      <= 1'b1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign linear_drive  = lin_drive_q;
	assign angular_drive = ang_drive_q;
	assign stop          = stop_q;
	assign reason        = reason_q;

	a_stop_matches_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (stop_q == (reason_q != REASON_ACTIVE)))
		else $error("stop flag disagrees with reason code");

	a_stop_zero_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && stop_q) |-> (lin_drive_q == '0 && ang_drive_q == '0))
		else $error("nonzero drive on a stop result");

	a_step_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && action_s1 == ACT_STEP && out_valid_q && !out_ready)
		|=> (valid_s1 && action_s1 == ACT_STEP))
		else $error("step beat lost while result register was full");

	a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |-> !in_ready)
		else $error("input accepted while stage one is blocked");

	a_bad_clock_brake: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && action_s1 == ACT_BRAKE && !time_valid_s1)
		|=> (!brake_seen_q && brake_engaged_q))
		else $error("brake beat with bad clock did not force the brake");

endmodule
